/* src/hcbd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the chunked body decoder.
// No dependencies; read first by every other file.
package hcbd_pkg;

	localparam int DATA_W         = 8;
	localparam int STATUS_W       = 3;
	localparam int TOTAL_W        = 33;
	localparam int MAX_W          = 32;
	localparam int SIZE_BITS_DEF  = 32;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 3;
	localparam int REG_IDX_LSB    = 2;

	localparam logic [APB_ADDR_W-REG_IDX_LSB-1:0] REG_MAX_BODY = '0;
	localparam logic [MAX_W-1:0]                  MAX_BODY_RST = '1;

	localparam logic [DATA_W-1:0] CHAR_CR = 8'h0d;
	localparam logic [DATA_W-1:0] CHAR_LF = 8'h0a;

	typedef enum logic [STATUS_W-1:0] {
		ST_BUSY     = 3'd0,
		ST_DONE     = 3'd1,
		ST_BAD      = 3'd2,
		ST_INCOMP   = 3'd3,
		ST_TOOLARGE = 3'd4
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0] out_byte;
		logic              out_valid;
		status_t           status;
	} result_t;

endpackage

/* src/hcbd_in_if.sv */
`timescale 1ns / 1ps
// Input channel: raw body bytes and the end marker, valid/ready handshake.
// Depends on hcbd_pkg.
interface hcbd_in_if;
	import hcbd_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              end_marker;

	modport source (output valid, output data_byte, output end_marker, input ready);
	modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

/* src/hcbd_out_if.sv */
`timescale 1ns / 1ps
// Output channel: one decoded result item per input item, valid/ready handshake.
// Depends on hcbd_pkg.
interface hcbd_out_if;
	import hcbd_pkg::*;

	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   out_byte;
	logic                out_valid;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output out_byte, output out_valid, output status, input ready);
	modport sink   (input valid, input out_byte, input out_valid, input status, output ready);
endinterface

/* src/http_chunked_body_decoder.sv */
`timescale 1ns / 1ps
// Top level of the chunked body decoder: input stage, APB register, result register.
// Depends on hcbd_pkg, hcbd_in_if, hcbd_out_if and hcbd_core.
//
//  channel    dir  protocol    payload
//  bytes_in   in   valid/ready data_byte, end_marker
//  bytes_out  out  valid/ready out_byte, out_valid, status
//  apb        in   APB r/w     max_body_bytes at byte address 0
//
// One item per cycle sustained while bytes_out.ready stays high. An accepted item
// passes through the input stage _s1, then the result register, from which it is
// taken. The framing state is updated in the same cycle as the result register.
// Reset returns the framing state to the start of a size line and
// max_body_bytes to all ones. A stalled result holds the input stage;
// bytes_in.ready falls only when both stages are full and unread.
module http_chunked_body_decoder #(
	parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	hcbd_in_if.sink                           bytes_in,
	hcbd_out_if.source                        bytes_out,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hcbd_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [hcbd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [hcbd_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import hcbd_pkg::*;

	logic [MAX_W-1:0]  max_body_q;
	logic              v_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              end_s1;
	logic              ov_q;
	result_t           res_q;
	result_t           res;
	logic              advance;
	logic              reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_MAX_BODY);
	assign prdata  = reg_sel ? APB_DATA_W'(max_body_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= MAX_BODY_RST;
		end else if (psel && penable && pwrite && reg_sel) begin
			max_body_q <= pwdata[MAX_W-1:0];
		end
	end

	assign advance        = v_s1 && (!ov_q || bytes_out.ready);
	assign bytes_in.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (bytes_in.ready) begin
			v_s1 <= bytes_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes_in.valid && bytes_in.ready) begin
			byte_s1 <= bytes_in.data_byte;
			end_s1  <= bytes_in.end_marker;
		end
	end

	hcbd_core #(
		.SIZE_BITS (SIZE_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (advance),
		.data_byte  (byte_s1),
		.end_marker (end_s1),
		.max_body   (max_body_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (advance) begin
			ov_q <= 1'b1;
		end else if (bytes_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign bytes_out.valid     = ov_q;
	assign bytes_out.out_byte  = res_q.out_byte;
	assign bytes_out.out_valid = res_q.out_valid;
	assign bytes_out.status    = res_q.status;

`ifndef NO_ASSERTIONS
	a_data_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && res_q.out_valid) |-> (res_q.status == ST_BUSY))
		else $error("data byte delivered with a final status");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !res_q.out_valid) |-> (res_q.out_byte == '0))
		else $error("out_byte not zero on a non-data item");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !bytes_out.ready && v_s1) |-> !bytes_in.ready)
		else $error("input taken while both stages are stalled");

	a_final_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.status != ST_BUSY) |=> (!advance || res.status == $past(res.status)))
		else $error("final status changed");
`endif

endmodule

/* src/hcbd_core.sv */
`timescale 1ns / 1ps
// Chunk framing state and the per-byte update; the result is combinational.
// Depends on hcbd_pkg.
module hcbd_core #(
	parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [hcbd_pkg::DATA_W-1:0]  data_byte,
	input  logic                         end_marker,
	input  logic [hcbd_pkg::MAX_W-1:0]   max_body,
	output hcbd_pkg::result_t            res
);
	import hcbd_pkg::*;

	typedef enum logic [2:0] {
		PH_SIZE    = 3'd0,
		PH_SIZE_LF = 3'd1,
		PH_DATA    = 3'd2,
		PH_DATA_CR = 3'd3,
		PH_DATA_LF = 3'd4
	} phase_t;

	phase_t               phase_q,  phase_d;
	logic [SIZE_BITS-1:0] size_q,   size_d;
	logic                 digit_q,  digit_d;
	logic [SIZE_BITS-1:0] left_q,   left_d;
	logic [TOTAL_W-1:0]   total_q,  total_d;
	status_t              status_q, status_d;

	logic       is_hex;
	logic [3:0] hex_val;

	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			hex_val = data_byte[3:0];
		end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
		             (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
			hex_val = data_byte[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		size_d   = size_q;
		digit_d  = digit_q;
		left_d   = left_q;
		total_d  = total_q;
		status_d = status_q;
		res.out_byte  = '0;
		res.out_valid = 1'b0;
		if (status_q == ST_BUSY) begin
			if (end_marker) begin
				status_d = ST_INCOMP;
			end else begin
				case (phase_q)
					PH_SIZE: begin
						if (data_byte == CHAR_CR) begin
							if (digit_q) phase_d = PH_SIZE_LF;
							else status_d = ST_BAD;
						end else if (!is_hex || size_q[SIZE_BITS-1 -: 4] != 4'd0) begin
							status_d = ST_BAD;
						end else begin
							size_d  = {size_q[SIZE_BITS-5:0], hex_val};
							digit_d = 1'b1;
						end
					end
					PH_SIZE_LF: begin
						if (data_byte != CHAR_LF) begin
							status_d = ST_BAD;
						end else if (size_q == '0) begin
							status_d = ST_DONE;
						end else begin
							left_d  = size_q;
							phase_d = PH_DATA;
						end
					end
					PH_DATA: begin
						res.out_byte  = data_byte;
						res.out_valid = 1'b1;
						if (total_q != '1) total_d = total_q + TOTAL_W'(1);
						left_d = left_q - SIZE_BITS'(1);
						if (left_q == SIZE_BITS'(1)) phase_d = PH_DATA_CR;
					end
					PH_DATA_CR: begin
						if (data_byte == CHAR_CR) phase_d = PH_DATA_LF;
						else status_d = ST_BAD;
					end
					PH_DATA_LF: begin
						if (data_byte != CHAR_LF) begin
							status_d = ST_BAD;
						end else if (total_q > {1'b0, max_body}) begin
							status_d = ST_TOOLARGE;
						end else begin
							phase_d = PH_SIZE;
							size_d  = '0;
							digit_d = 1'b0;
						end
					end
					default: status_d = ST_BAD;
				endcase
			end
		end
		res.status = status_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIZE;
			size_q   <= '0;
			digit_q  <= 1'b0;
			left_q   <= '0;
			total_q  <= '0;
			status_q <= ST_BUSY;
		end else if (take) begin
			phase_q  <= phase_d;
			size_q   <= size_d;
			digit_q  <= digit_d;
			left_q   <= left_d;
			total_q  <= total_d;
			status_q <= status_d;
		end
	end

endmodule
